/* rtl/mastep_pkg.sv */
`default_nettype none
package mastep_pkg;

  // Axis geometry and pulse timing.
  localparam int unsigned AXES        = 4;
  localparam int unsigned AXIS_W      = 2;
  localparam int unsigned PHASE_TICKS = 2;
  localparam int unsigned POS_W       = 32;

  // Stream channel payload widths.
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_LOW  = 2'd2;

  // Command codes.
  localparam logic [2:0] CMD_MOVE    = 3'd0;
  localparam logic [2:0] CMD_SET_POS = 3'd1;
  localparam logic [2:0] CMD_READ    = 3'd2;
  localparam logic [2:0] CMD_TICK    = 3'd3;
  localparam logic [2:0] CMD_ENABLE  = 3'd4;
  localparam logic [2:0] CMD_DISABLE = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  // Pulse phase codes.
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;
  localparam logic [1:0] PH_DELAY = 2'd3;

  // What the second stage does to the addressed position.
  typedef enum logic [1:0] {
    POS_KEEP,
    POS_LOAD,
    POS_INC,
    POS_DEC
  } pos_op_e;

  // Write port of the position store.
  typedef struct packed {
    logic              en;
    logic [AXIS_W-1:0] addr;
    logic [POS_W-1:0]  data;
  } pos_wr_t;

endpackage
`default_nettype wire

/* rtl/mastep_pos_ram.sv */
`default_nettype none
module mastep_pos_ram (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [mastep_pkg::AXIS_W-1:0] rd_addr_i,
  input  wire mastep_pkg::pos_wr_t           wr_i,
  output logic      [mastep_pkg::POS_W-1:0]  rd_data_o
);
  import mastep_pkg::*;

  logic [POS_W-1:0] mem [AXES];
  logic [AXES-1:0]  written_q;
  logic [POS_W-1:0] rd_data_q;
  logic             rd_written_q;
  logic             fwd_q;
  logic [POS_W-1:0] fwd_data_q;

  // Storage array: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  // A write landing on the entry read in the same cycle is forwarded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_i.en && (wr_i.addr == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_i.data;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (rd_written_q ? rd_data_q : '0);

endmodule
`default_nettype wire

/* rtl/multi_axis_step_dir_generator_core.sv */
`default_nettype none
// A result passes the first-stage and output registers before it is offered.
// Throughput: one item per cycle unless the output stalls; the position store
// reads in stage one, writes back in stage two, forwarding between neighbors.
// Reset: asynchronous, active low; control state, configuration and valid flags
// clear, positions read zero at once via written bits, no clearing pass.
module multi_axis_step_dir_generator_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration writes.
  input  wire logic                                  cfg_we_i,
  input  wire logic [mastep_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mastep_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Command stream.
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // axis_index[7:0], step_count[39:8], step_delay[71:40], new_position[103:72]
  input  wire logic [mastep_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // command[2:0]
  input  wire logic [mastep_pkg::IN_USER_W-1:0]      s_axis_tuser_i,
  // Result stream.
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // step_level[0], step_axis[2:1], dir_level[3], enable_level[4], moving[5],
  // position_out[37:6], zero fill[39:38]
  output logic [mastep_pkg::OUT_DATA_W-1:0]          m_axis_tdata_o,
  // status[1:0]
  output logic [mastep_pkg::OUT_USER_W-1:0]          m_axis_tuser_o
);
  import mastep_pkg::*;

  typedef struct packed {
    pos_op_e           op;
    logic [AXIS_W-1:0] addr;
    logic [POS_W-1:0]  npos;
    logic              zero_pos;
    logic [1:0]        status;
    logic              step_level;
    logic [AXIS_W-1:0] step_axis;
    logic              dir_level;
    logic              enable_level;
    logic              moving;
  } stage_t;

  localparam logic [2:0]        AXES_N      = 3'(AXES);
  localparam logic [POS_W-1:0]  PHASE_LOAD  = POS_W'(PHASE_TICKS);
  localparam logic [30:0]       STEPS_MAX   = '1;

  // Configuration registers.
  logic [2:0]      axis_count_q;
  logic [AXES-1:0] dir_invert_q;
  logic            enable_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_count_q <= '0;
      dir_invert_q <= '0;
      enable_low_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_AXIS_COUNT: axis_count_q <= cfg_data_i[2:0];
        CFG_DIR_INVERT: dir_invert_q <= cfg_data_i[AXES-1:0];
        CFG_ENABLE_LOW: enable_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Move state.
  logic              drv_en_q,   drv_en_d;
  logic              active_q,   active_d;
  logic [AXIS_W-1:0] cur_axis_q, cur_axis_d;
  logic [30:0]       steps_q,    steps_d;
  logic              fwd_q,      fwd_d;
  logic [1:0]        phase_q,    phase_d;
  logic [POS_W-1:0]  ticks_q,    ticks_d;
  logic [POS_W-1:0]  delay_q,    delay_d;
  logic [AXES-1:0]   dir_lv_q,   dir_lv_d;

  // Pipeline handshake.
  logic   s1_valid_q, out_valid_q;
  stage_t s1_q, s1_d;
  logic   in_xfer, s1_adv;

  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Input fields.
  logic [2:0]       cmd;
  logic [7:0]       ax;
  logic [POS_W-1:0] cnt, dly, npos;

  assign cmd  = s_axis_tuser_i;
  assign ax   = s_axis_tdata_i[7:0];
  assign cnt  = s_axis_tdata_i[39:8];
  assign dly  = s_axis_tdata_i[71:40];
  assign npos = s_axis_tdata_i[103:72];

  logic [2:0]       axes_used;
  logic             ax_ok;
  logic [POS_W-1:0] mag;
  logic             move_fwd;
  logic [30:0]      steps_dec;

  assign axes_used = (axis_count_q > AXES_N) ? AXES_N : axis_count_q;
  assign ax_ok     = ax < {5'd0, axes_used};
  assign move_fwd  = !cnt[POS_W-1];
  assign mag       = move_fwd ? cnt : (POS_W'(0) - cnt);
  assign steps_dec = steps_q - 31'd1;

  // First stage: command decode and control-state update.
  always_comb begin
    drv_en_d   = drv_en_q;
    active_d   = active_q;
    cur_axis_d = cur_axis_q;
    steps_d    = steps_q;
    fwd_d      = fwd_q;
    phase_d    = phase_q;
    ticks_d    = ticks_q;
    delay_d    = delay_q;
    dir_lv_d   = dir_lv_q;
    s1_d          = '0;
    s1_d.op       = POS_KEEP;
    s1_d.npos     = npos;
    s1_d.status   = ST_OK;

    case (cmd)
      CMD_MOVE: begin
        if (!ax_ok) begin
          s1_d.status = ST_INVALID;
        end else if (active_q) begin
          s1_d.status = ST_BUSY;
        end else if (cnt != '0) begin
          drv_en_d              = 1'b1;
          dir_lv_d[ax[AXIS_W-1:0]] = move_fwd ^ dir_invert_q[ax[AXIS_W-1:0]];
          cur_axis_d            = ax[AXIS_W-1:0];
          fwd_d                 = move_fwd;
          steps_d               = mag[POS_W-1] ? STEPS_MAX : mag[30:0];
          delay_d               = dly;
          phase_d               = PH_SETUP;
          ticks_d               = PHASE_LOAD;
          active_d              = 1'b1;
        end
      end
      CMD_SET_POS: begin
        if (!ax_ok) begin
          s1_d.status = ST_INVALID;
        end else if (active_q) begin
          s1_d.status = ST_BUSY;
        end else begin
          s1_d.op = POS_LOAD;
        end
      end
      CMD_READ: begin
        if (!ax_ok) begin
          s1_d.status = ST_INVALID;
        end
      end
      CMD_TICK: begin
        if (active_q) begin
          if (ticks_q > 32'd1) begin
            ticks_d = ticks_q - 32'd1;
          end else begin
            case (phase_q)
              PH_LOW: begin
                phase_d = PH_HIGH;
                ticks_d = PHASE_LOAD;
              end
              PH_HIGH: begin
                // End of a step: count position, then delay, next pulse or end of move.
                s1_d.op = fwd_q ? POS_INC : POS_DEC;
                steps_d = steps_dec;
                if (delay_q != '0) begin
                  phase_d = PH_DELAY;
                  ticks_d = delay_q;
                end else if (steps_dec == '0) begin
                  active_d = 1'b0;
                  phase_d  = PH_SETUP;
                  ticks_d  = '0;
                end else begin
                  phase_d = PH_LOW;
                  ticks_d = PHASE_LOAD;
                end
              end
              default: begin
                if (phase_q == PH_DELAY && steps_q == '0) begin
                  active_d = 1'b0;
                  phase_d  = PH_SETUP;
                  ticks_d  = '0;
                end else begin
                  phase_d = PH_LOW;
                  ticks_d = PHASE_LOAD;
                end
              end
            endcase
          end
        end
      end
      CMD_ENABLE, CMD_DISABLE: begin
        if (active_q) begin
          s1_d.status = ST_BUSY;
        end else begin
          drv_en_d = (cmd == CMD_ENABLE);
        end
      end
      default: ;
    endcase

    // Set and read address the given axis; all else the active axis.
    if (cmd == CMD_SET_POS || cmd == CMD_READ) begin
      s1_d.addr     = ax[AXIS_W-1:0];
      s1_d.zero_pos = !ax_ok;
    end else begin
      s1_d.addr = cur_axis_d;
    end
    s1_d.step_level   = !(active_d && phase_d == PH_LOW);
    s1_d.step_axis    = cur_axis_d;
    s1_d.dir_level    = dir_lv_d[cur_axis_d];
    s1_d.enable_level = drv_en_d ^ enable_low_q;
    s1_d.moving       = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_en_q   <= 1'b0;
      active_q   <= 1'b0;
      cur_axis_q <= '0;
      steps_q    <= '0;
      fwd_q      <= 1'b0;
      phase_q    <= PH_SETUP;
      ticks_q    <= '0;
      delay_q    <= '0;
      dir_lv_q   <= '0;
    end else if (in_xfer) begin
      drv_en_q   <= drv_en_d;
      active_q   <= active_d;
      cur_axis_q <= cur_axis_d;
      steps_q    <= steps_d;
      fwd_q      <= fwd_d;
      phase_q    <= phase_d;
      ticks_q    <= ticks_d;
      delay_q    <= delay_d;
      dir_lv_q   <= dir_lv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= s1_d;
    end
  end

  // Second stage: read-modify-write of the addressed position.
  pos_wr_t          pos_wr;
  logic [POS_W-1:0] pos_old, pos_new, pos_out;

  mastep_pos_ram u_pos_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (s1_d.addr),
    .wr_i      (pos_wr),
    .rd_data_o (pos_old)
  );

  always_comb begin
    case (s1_q.op)
      POS_LOAD: pos_new = s1_q.npos;
      POS_INC:  pos_new = pos_old + 32'd1;
      POS_DEC:  pos_new = pos_old - 32'd1;
      default:  pos_new = pos_old;
    endcase
  end

  assign pos_wr.en   = s1_adv && (s1_q.op != POS_KEEP);
  assign pos_wr.addr = s1_q.addr;
  assign pos_wr.data = pos_new;
  assign pos_out     = s1_q.zero_pos ? '0 : pos_new;

  // Output register holds a result until its transfer.
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= {2'b00, pos_out, s1_q.moving, s1_q.enable_level,
                     s1_q.dir_level, s1_q.step_axis, s1_q.step_level};
      out_user_q <= s1_q.status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
`default_nettype wire
